### hw/rtl/tgst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgst_pkg
// shared widths, register codes, reset values and control structs for the
// two-gate speed trap
// ----------------------------------------------------------------------------
package tgst_pkg;

  // sizing
  localparam int COUNT_WIDTH   = 16;
  localparam int SAMPLE_WIDTH  = 10;
  localparam int THRESH_WIDTH  = 10;
  localparam int DIST_WIDTH    = 20;
  localparam int PERIOD_WIDTH  = 20;
  localparam int ELAPSED_WIDTH = 16;
  localparam int SPEED_WIDTH   = 30;
  localparam int SCALE_WIDTH   = 10;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 20;

  localparam int DIFF_WIDTH =
    ((SAMPLE_WIDTH > THRESH_WIDTH) ? SAMPLE_WIDTH : THRESH_WIDTH) + 1;
  localparam int NUM_WIDTH     = DIST_WIDTH + SCALE_WIDTH;
  localparam int DEN_WIDTH     = COUNT_WIDTH + PERIOD_WIDTH;
  localparam int DIV_CNT_WIDTH = $clog2(SPEED_WIDTH);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [SCALE_WIDTH-1:0] UM_PER_MM = SCALE_WIDTH'(1000);

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_RISE_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_GATE_DISTANCE_UM = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TICK_PERIOD_US   = 2'd2;

  // register reset values
  localparam logic [THRESH_WIDTH-1:0] RISE_THRESHOLD_RST   = THRESH_WIDTH'(10);
  localparam logic [DIST_WIDTH-1:0]   GATE_DISTANCE_UM_RST = DIST_WIDTH'(70000);
  localparam logic [PERIOD_WIDTH-1:0] TICK_PERIOD_US_RST   = PERIOD_WIDTH'(50000);

  // controller to datapath
  typedef struct packed {
    logic accept;    // take the input item into the tracking state
    logic start_mul; // form numerator and denominator
    logic div_step;  // one restoring divide step
    logic load_out;  // move result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic second_hit; // item on the input ends a measurement
  } dp_status_t;

endpackage : tgst_pkg
`default_nettype wire

### hw/rtl/tgst_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgst_if
// valid/ready channels for sample items and result items
// ----------------------------------------------------------------------------
interface tgst_in_if;
  import tgst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] first_gate_sample;
  logic [SAMPLE_WIDTH-1:0] second_gate_sample;

  modport source (output valid, output first_gate_sample, output second_gate_sample,
                  input ready);
  modport sink   (input valid, input first_gate_sample, input second_gate_sample,
                  output ready);
endinterface : tgst_in_if

interface tgst_out_if;
  import tgst_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ELAPSED_WIDTH-1:0] elapsed_ticks;
  logic [SPEED_WIDTH-1:0]   speed_mm_per_s;
  logic                     count_saturated;

  modport source (output valid, output elapsed_ticks, output speed_mm_per_s,
                  output count_saturated, input ready);
  modport sink   (input valid, input elapsed_ticks, input speed_mm_per_s,
                  input count_saturated, output ready);
endinterface : tgst_out_if
`default_nettype wire

### hw/rtl/two_gate_speed_trap_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_gate_speed_trap_unit
// light-gate chronograph: tick timing between two gates and speed in mm/s
// ----------------------------------------------------------------------------
// Each input item is one sample tick with both sensor samples. An item that
// does not end a measurement is absorbed on acceptance, so ticks can stream
// back to back. An item on which the second gate fires stops intake until its
// result is handed on, in order: the intake, a step forming distance*1000 and
// ticks*period, 30 steps of the restoring divider (one quotient bit per cycle)
// and a step handing the result to the output register. The output register
// holds a finished result until it is taken, and sample items keep being
// accepted meanwhile; only a second result waits in the sequencer for the
// register to empty. A zero tick period yields the speed field maximum.
// Configuration writes go straight to the registers and are meant for idle
// periods.
// ----------------------------------------------------------------------------
module two_gate_speed_trap_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [tgst_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [tgst_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
  tgst_in_if.sink                                 in_ch,
  tgst_out_if.source                              out_ch
);
  import tgst_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // sequencer: owns the handshakes and the divide step count
  tgst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: gate tracking, counter, config, arithmetic, output payload
  tgst_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .first_gate_sample  (in_ch.first_gate_sample),
    .second_gate_sample (in_ch.second_gate_sample),
    .cmd                (cmd),
    .sts                (sts),
    .elapsed_ticks      (out_ch.elapsed_ticks),
    .speed_mm_per_s     (out_ch.speed_mm_per_s),
    .count_saturated    (out_ch.count_saturated)
  );

  // a result never overwrites one still waiting at the output
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result loaded over a pending output item");

  // a measurement-ending item stops intake for the divide
  a_busy_after_hit: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.second_hit) |=> !in_ch.ready)
    else $error("intake not stopped after second gate detection");

  // output valid only rises from a load command
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(cmd.load_out))
    else $error("output valid rose without a load");

  // divider never runs while intake is open
  a_no_step_when_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step || cmd.start_mul) |-> !in_ch.ready)
    else $error("divider active while accepting items");

endmodule : two_gate_speed_trap_unit
`default_nettype wire

### hw/rtl/tgst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgst_ctrl
// sequencer: item intake, multiply, divide steps, output register handoff
// ----------------------------------------------------------------------------
module tgst_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire tgst_pkg::dp_status_t sts,
  output tgst_pkg::ctrl_cmd_t     cmd
);
  import tgst_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(SPEED_WIDTH - 1);

  logic [1:0]               state, state_next;
  logic [DIV_CNT_WIDTH-1:0] div_cnt, div_cnt_next;
  logic                     out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    div_cnt_next   = div_cnt;
    cmd            = '0;
    cmd.accept     = in_valid && in_ready;
    case (state)
      ST_IDLE: begin
        if (cmd.accept && sts.second_hit) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.start_mul = 1'b1;
        div_cnt_next  = '0;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to be free
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule : tgst_ctrl
`default_nettype wire

### hw/rtl/tgst_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgst_dp
// gate tracking, tick counter, config registers, multiply and restoring divider
// ----------------------------------------------------------------------------
module tgst_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [tgst_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [tgst_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
  input  wire logic [tgst_pkg::SAMPLE_WIDTH-1:0]   first_gate_sample,
  input  wire logic [tgst_pkg::SAMPLE_WIDTH-1:0]   second_gate_sample,
  input  wire tgst_pkg::ctrl_cmd_t                cmd,
  output tgst_pkg::dp_status_t                    sts,
  output logic [tgst_pkg::ELAPSED_WIDTH-1:0]       elapsed_ticks,
  output logic [tgst_pkg::SPEED_WIDTH-1:0]         speed_mm_per_s,
  output logic                                    count_saturated
);
  import tgst_pkg::*;

  // config registers
  logic [THRESH_WIDTH-1:0] rise_threshold;
  logic [DIST_WIDTH-1:0]   gate_distance_um;
  logic [PERIOD_WIDTH-1:0] tick_period_us;

  // tracking state
  logic                    timing_phase;
  logic [SAMPLE_WIDTH-1:0] last_first_sample;
  logic                    first_sample_valid;
  logic [SAMPLE_WIDTH-1:0] last_second_sample;
  logic                    second_sample_valid;
  logic [COUNT_WIDTH-1:0]  tick_count;
  logic                    saturated_flag;

  // captured measurement and divider
  logic [COUNT_WIDTH-1:0]  res_ticks;
  logic                    res_sat;
  logic [SPEED_WIDTH-1:0]  quot;
  logic [DEN_WIDTH-1:0]    den;
  logic [DEN_WIDTH-1:0]    rem;

  logic [DIFF_WIDTH-1:0]   diff_first, diff_second, thr_ext;
  logic                    first_hit, second_hit;
  logic [COUNT_WIDTH-1:0]  tick_count_next;
  logic                    saturated_next;
  logic [NUM_WIDTH-1:0]    num_prod;
  logic [DEN_WIDTH-1:0]    den_prod;
  logic [DEN_WIDTH:0]      rem_sh;
  logic [DEN_WIDTH:0]      rem_sub;
  logic                    q_bit;

  // rise detection: unsigned difference, borrow bit means no rise
  assign thr_ext     = DIFF_WIDTH'(rise_threshold);
  assign diff_first  = DIFF_WIDTH'(first_gate_sample) - DIFF_WIDTH'(last_first_sample);
  assign diff_second = DIFF_WIDTH'(second_gate_sample) - DIFF_WIDTH'(last_second_sample);
  assign first_hit   = first_sample_valid && !diff_first[DIFF_WIDTH-1]
                       && (diff_first > thr_ext);
  assign second_hit  = second_sample_valid && !diff_second[DIFF_WIDTH-1]
                       && (diff_second > thr_ext);

  assign sts.second_hit = timing_phase && second_hit;

  // saturating tick counter
  assign tick_count_next = (tick_count == COUNT_MAX) ? tick_count : tick_count + 1'b1;
  assign saturated_next  = saturated_flag || (tick_count_next == COUNT_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_threshold   <= RISE_THRESHOLD_RST;
      gate_distance_um <= GATE_DISTANCE_UM_RST;
      tick_period_us   <= TICK_PERIOD_US_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RISE_THRESHOLD:   rise_threshold   <= cfg_wdata[THRESH_WIDTH-1:0];
        REG_GATE_DISTANCE_UM: gate_distance_um <= cfg_wdata[DIST_WIDTH-1:0];
        REG_TICK_PERIOD_US:   tick_period_us   <= cfg_wdata[PERIOD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timing_phase        <= 1'b0;
      first_sample_valid  <= 1'b0;
      second_sample_valid <= 1'b0;
      tick_count          <= '0;
      saturated_flag      <= 1'b0;
    end else if (cmd.accept) begin
      if (!timing_phase) begin
        last_first_sample  <= first_gate_sample;
        first_sample_valid <= 1'b1;
        if (first_hit) begin
          timing_phase        <= 1'b1;
          tick_count          <= '0;
          saturated_flag      <= 1'b0;
          last_second_sample  <= second_gate_sample;
          second_sample_valid <= 1'b1;
        end
      end else begin
        last_second_sample <= second_gate_sample;
        if (second_hit) begin
          res_ticks           <= tick_count_next;
          res_sat             <= saturated_next;
          timing_phase        <= 1'b0;
          first_sample_valid  <= 1'b0;
          second_sample_valid <= 1'b0;
          tick_count          <= '0;
          saturated_flag      <= 1'b0;
        end else begin
          tick_count          <= tick_count_next;
          saturated_flag      <= saturated_next;
          second_sample_valid <= 1'b1;
        end
      end
    end
  end

  // operands
  assign num_prod = gate_distance_um * UM_PER_MM;
  assign den_prod = res_ticks * tick_period_us;

  // restoring divide, one quotient bit per step; a zero divisor gives all ones
  assign rem_sh  = {rem, quot[SPEED_WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign q_bit   = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (cmd.start_mul) begin
      quot <= num_prod[SPEED_WIDTH-1:0];
      den  <= den_prod;
      rem  <= '0;
    end else if (cmd.div_step) begin
      rem  <= q_bit ? rem_sub[DEN_WIDTH-1:0] : rem_sh[DEN_WIDTH-1:0];
      quot <= {quot[SPEED_WIDTH-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      elapsed_ticks   <= ELAPSED_WIDTH'(res_ticks);
      speed_mm_per_s  <= quot;
      count_saturated <= res_sat;
    end
  end

endmodule : tgst_dp
`default_nettype wire

### tb/two_gate_speed_trap_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_gate_speed_trap_unit_tb
// self-checking bench for the light-gate chronograph: sample ticks go in on a
// valid/ready channel and a tracking model of both gates predicts every
// speed report. Covers threshold edges, re-arming, zero distance and period,
// and randomized register settings under back-pressure.
// ----------------------------------------------------------------------------
module two_gate_speed_trap_unit_tb;
  import tgst_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned SETTLE_CYCLES = 40;  // divider pass plus margin
  localparam logic [63:0] SPEED_CEIL = (64'd1 << SPEED_WIDTH) - 64'd1;

  // one sample tick, both sensors
  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] first_gate;
    logic [SAMPLE_WIDTH-1:0] second_gate;
  } gate_tick_t;

  // one speed report
  typedef struct packed {
    logic [ELAPSED_WIDTH-1:0] elapsed;
    logic [SPEED_WIDTH-1:0]   speed;
    logic                     saturated;
  } trap_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;

  tgst_in_if  sample_ch ();
  tgst_out_if report_ch ();

  two_gate_speed_trap_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (sample_ch),
    .out_ch    (report_ch)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // bench-side copy of the registers and the gate tracking state
  // --------------------------------------------------------------------------
  logic [THRESH_WIDTH-1:0] rise_thr  = RISE_THRESHOLD_RST;
  logic [DIST_WIDTH-1:0]   gate_um   = GATE_DISTANCE_UM_RST;
  logic [PERIOD_WIDTH-1:0] period_us = TICK_PERIOD_US_RST;

  logic                    timing_run  = 1'b0;  // low: armed on the first gate
  logic [SAMPLE_WIDTH-1:0] last_first  = '0;
  logic                    first_seen  = 1'b0;
  logic [SAMPLE_WIDTH-1:0] last_second = '0;
  logic                    second_seen = 1'b0;
  logic [COUNT_WIDTH-1:0]  run_ticks   = '0;
  logic                    run_sat     = 1'b0;

  gate_tick_t   pending_ticks[$];          // items waiting for the driver
  trap_report_t pending_speed_reports[$];  // predicted reports, oldest first

  int unsigned samples_queued  = 0;
  int unsigned samples_taken   = 0;
  int unsigned reports_checked = 0;
  int unsigned reg_writes      = 0;
  int unsigned fail_count      = 0;
  int unsigned cycle_count     = 0;

  logic send_gaps_on = 1'b1;
  logic stalls_on    = 1'b1;
  int unsigned send_gap = 0;
  int unsigned hold_off = 0;

  // a detection needs a strictly larger sample, by more than the threshold
  function automatic logic crossed(input logic [SAMPLE_WIDTH-1:0] cur,
                                   input logic [SAMPLE_WIDTH-1:0] prev);
    return (cur > prev) && ((cur - prev) > rise_thr);
  endfunction

  // mostly back to back, sometimes a few cycles, rarely a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // advance the gate tracking by one accepted tick, queue a report on a hit
  task automatic advance_trap(input logic [SAMPLE_WIDTH-1:0] s1,
                              input logic [SAMPLE_WIDTH-1:0] s2);
    trap_report_t rep;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [63:0]  quo;
    logic         fired;
    if (!timing_run) begin
      // armed: only the first gate is watched, second gate ignored
      fired = first_seen && crossed(s1, last_first);
      last_first = s1;
      first_seen = 1'b1;
      if (fired) begin
        timing_run  = 1'b1;
        run_ticks   = '0;
        run_sat     = 1'b0;
        last_second = s2;
        second_seen = 1'b1;
      end
    end else begin
      // counter sticks at its maximum and flags it
      if (run_ticks != COUNT_MAX) run_ticks++;
      if (run_ticks == COUNT_MAX) run_sat = 1'b1;
      fired = second_seen && crossed(s2, last_second);
      last_second = s2;
      second_seen = 1'b1;
      if (fired) begin
        num = 64'(gate_um) * 64'd1000;
        den = 64'(run_ticks) * 64'(period_us);
        quo = (den == 64'd0) ? SPEED_CEIL : num / den;
        if (quo > SPEED_CEIL) quo = SPEED_CEIL;
        rep.elapsed   = run_ticks[ELAPSED_WIDTH-1:0];
        rep.speed     = quo[SPEED_WIDTH-1:0];
        rep.saturated = run_sat;
        pending_speed_reports.push_back(rep);
        // re-arm with no valid first-gate baseline
        timing_run  = 1'b0;
        first_seen  = 1'b0;
        second_seen = 1'b0;
        run_ticks   = '0;
        run_sat     = 1'b0;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // input side: driver and predictor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_ticks
    gate_tick_t next_tick;
    if (rst) begin
      sample_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!sample_ch.valid || sample_ch.ready) begin
      if (send_gap != 0) begin
        sample_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_ticks.size() != 0) begin
        next_tick = pending_ticks.pop_front();
        sample_ch.valid <= 1'b1;
        sample_ch.first_gate_sample  <= next_tick.first_gate;
        sample_ch.second_gate_sample <= next_tick.second_gate;
        send_gap <= send_gaps_on ? pick_gap() : 0;
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      advance_trap(sample_ch.first_gate_sample, sample_ch.second_gate_sample);
      samples_taken <= samples_taken + 1;
    end
  end

  // --------------------------------------------------------------------------
  // output side: random back-pressure and report checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : take_reports
    trap_report_t want;
    if (rst) begin
      report_ch.ready <= 1'b0;
      hold_off <= 0;
    end else begin
      if (report_ch.valid && report_ch.ready) begin
        if (pending_speed_reports.size() == 0) begin
          $display("%0t: unexpected report: ticks %0d speed %0d saturated %0b", $time,
                   report_ch.elapsed_ticks, report_ch.speed_mm_per_s,
                   report_ch.count_saturated);
          fail_count++;
        end else begin
          want = pending_speed_reports.pop_front();
          reports_checked++;
          if (report_ch.elapsed_ticks !== want.elapsed) begin
            $display("%0t: elapsed_ticks expected %0d actual %0d", $time, want.elapsed,
                     report_ch.elapsed_ticks);
            fail_count++;
          end
          if (report_ch.speed_mm_per_s !== want.speed) begin
            $display("%0t: speed_mm_per_s expected %0d actual %0d", $time, want.speed,
                     report_ch.speed_mm_per_s);
            fail_count++;
          end
          if (report_ch.count_saturated !== want.saturated) begin
            $display("%0t: count_saturated expected %0b actual %0b", $time,
                     want.saturated, report_ch.count_saturated);
            fail_count++;
          end
        end
      end
      if (hold_off != 0) begin
        report_ch.ready <= 1'b0;
        hold_off <= hold_off - 1;
      end else begin
        report_ch.ready <= 1'b1;
        if (stalls_on && $urandom_range(0, 3) == 0) hold_off <= pick_gap();
      end
    end
  end

  // hard stop
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still due", cycle_count,
               pending_speed_reports.size());
      $display("[two_gate_speed_trap_unit] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_tick(input int unsigned s1, input int unsigned s2);
    gate_tick_t t;
    t.first_gate  = SAMPLE_WIDTH'(s1);
    t.second_gate = SAMPLE_WIDTH'(s2);
    pending_ticks.push_back(t);
    samples_queued++;
  endtask

  // registers only change while nothing is in flight
  task automatic set_trap_config(input int unsigned thr, input int unsigned gate_dist,
                                 input int unsigned per);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RISE_THRESHOLD;
    cfg_wdata <= CFG_DATA_WIDTH'(thr);
    @(posedge clk);
    cfg_index <= REG_GATE_DISTANCE_UM;
    cfg_wdata <= CFG_DATA_WIDTH'(gate_dist);
    @(posedge clk);
    cfg_index <= REG_TICK_PERIOD_US;
    cfg_wdata <= CFG_DATA_WIDTH'(per);
    @(posedge clk);
    cfg_we <= 1'b0;
    rise_thr  = THRESH_WIDTH'(thr);
    gate_um   = DIST_WIDTH'(gate_dist);
    period_us = PERIOD_WIDTH'(per);
    reg_writes += 3;
  endtask

  // sender holds off until every item is in and every report is out
  task automatic wait_trap_idle();
    while (samples_taken != samples_queued || pending_speed_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // well-formed pass: baseline, first-gate hit, timing ticks, second-gate hit
  task automatic queue_pass(input int unsigned n_timing);
    int unsigned thr;
    int unsigned b1;
    int unsigned lvl2;
    thr  = rise_thr;
    b1   = $urandom_range(0, 1022 - thr);
    lvl2 = $urandom_range(0, 1022 - thr);
    queue_tick(b1, $urandom);
    queue_tick(b1 + thr + 1 + $urandom_range(0, 1022 - thr - b1), lvl2);
    repeat (n_timing - 1) begin
      // near miss: a rise of exactly the threshold must not fire
      if ($urandom_range(0, 5) == 0 && lvl2 + 2 * thr + 1 <= 1023) lvl2 += thr;
      else lvl2 -= $urandom_range(0, (lvl2 < 6) ? lvl2 : 6);
      queue_tick($urandom, lvl2);
    end
    queue_tick($urandom, lvl2 + thr + 1 + $urandom_range(0, 1022 - thr - lvl2));
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned goal;
    int unsigned thr;
    int unsigned gate_dist;
    int unsigned per;
    sample_ch.valid = 1'b0;
    sample_ch.first_gate_sample  = '0;
    sample_ch.second_gate_sample = '0;
    report_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset registers: threshold 10, 70 mm, 50 ms
    queue_tick(1023, 1023);  // no previous sample, only loads the baseline
    queue_tick(0, 0);        // falling
    queue_tick(10, 1023);    // rise equal to threshold, no hit
    queue_tick(21, 0);       // rise of 11 starts timing, second baseline 0
    queue_tick(1023, 10);    // second gate rise equal to threshold
    queue_tick(0, 21);       // hit after 2 ticks
    queue_tick(0, 1023);     // fresh baseline after re-arm
    queue_tick(1023, 512);   // full-scale rise
    queue_tick(512, 1023);   // hit after a single tick
    queue_tick(100, 0);
    queue_tick(100, 1023);   // second gate jumps while armed, ignored
    queue_tick(682, 5);
    queue_tick(341, 4);
    queue_tick(0, 1023);
    wait_trap_idle();

    // zero threshold, zero distance, widest period
    set_trap_config(0, 0, 20'hFFFFF);
    queue_tick(7, 0);
    queue_tick(8, 0);        // rise of one is enough
    queue_tick(341, 1);
    wait_trap_idle();

    // widest threshold: nothing can fire
    set_trap_config(1023, 20'hFFFFF, 0);
    queue_tick(0, 0);
    queue_tick(1023, 1023);
    wait_trap_idle();

    // zero period gives the speed field maximum
    set_trap_config(5, 20'hFFFFF, 0);
    queue_tick(0, 0);
    queue_tick(682, 3);
    queue_tick(0, 100);
    wait_trap_idle();

    // widest distance over the shortest period
    set_trap_config(0, 20'hFFFFF, 1);
    queue_pass(1);
    wait_trap_idle();

    // random register settings, mostly well-formed passes with some noise
    repeat (5) begin
      thr  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 40) : $urandom_range(41, 300);
      case ($urandom_range(0, 9))
        0:       gate_dist = 0;
        1:       gate_dist = 20'hFFFFF;
        default: gate_dist = $urandom_range(1, 20'hFFFFF);
      endcase
      case ($urandom_range(0, 9))
        0:       per = 0;
        1:       per = $urandom_range(1, 100);
        2:       per = 20'hFFFFF;
        default: per = $urandom_range(1, 20'hFFFFF);
      endcase
      set_trap_config(thr, gate_dist, per);
      send_gaps_on <= ($urandom_range(0, 3) != 0);
      stalls_on    <= ($urandom_range(0, 3) != 0);
      goal = samples_queued + 100;
      while (samples_queued < goal) begin
        // halfway through, let everything drain before going on
        if (samples_queued + 50 >= goal && samples_queued + 50 < goal + 12) wait_trap_idle();
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 6)) queue_tick($urandom, $urandom);
        end else if ($urandom_range(0, 9) == 0) begin
          queue_pass($urandom_range(9, 40));
        end else begin
          queue_pass($urandom_range(1, 8));
        end
      end
      wait_trap_idle();
    end

    $display("%0d sample items, %0d speed reports checked, %0d register writes",
             samples_queued, reports_checked, reg_writes);
    $display("threshold edges, re-arming, zero distance and period, random settings covered");
    if (fail_count == 0) begin
      $display("[two_gate_speed_trap_unit] OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[two_gate_speed_trap_unit] ERROR");
    end
    $finish;
  end

endmodule : two_gate_speed_trap_unit_tb
